>>> sv/spi_dfr_pkg.sv
// Types and constants for the SPI receive-buffer Ethernet deframer.
// No dependencies; used by all deframer modules and the testbench.
package spi_dfr_pkg;

   // Frame parsing phase; code 7 is unused and behaves as discard
   typedef enum logic [2:0] {
      PH_OUTER   = 3'd0,
      PH_START   = 3'd1,
      PH_INNER   = 3'd2,
      PH_RSVD    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_TRAILER = 3'd5,
      PH_DISCARD = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD    = 2'd0,
      KIND_HDR_ERROR  = 2'd1,
      KIND_BUFFER_END = 2'd2
   } kind_type;

   localparam logic [7:0]  START_BYTE     = 8'hAA;
   // header byte offsets
   localparam logic [15:0] POS_OUTER_HI   = 16'd2;
   localparam logic [15:0] POS_OUTER_LO   = 16'd3;
   localparam logic [15:0] POS_START_LO   = 16'd4;
   localparam logic [15:0] POS_START_HI   = 16'd7;
   localparam logic [15:0] POS_INNER_LO   = 16'd8;
   localparam logic [15:0] POS_INNER_HI   = 16'd9;
   localparam logic [15:0] POS_CHECK      = 16'd10;
   localparam logic [15:0] POS_HDR_END    = 16'd12;
   localparam logic [15:0] TRAILER_BYTES  = 16'd2;
   localparam logic [16:0] LEN_ADJUST     = 17'd10;
   localparam logic [16:0] FRAME_OVERHEAD = 17'd4;
   localparam logic [7:0]  FRAME_MAX      = 8'd255;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  frame_index;
      logic [15:0] payload_length;
      logic        last_of_frame;
      logic        buffer_done;
      logic        truncated;
   } rsp_item_type;

endpackage

>>> sv/spi_dfr_if.sv
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Depends on nothing; payload fields mirror spi_dfr_pkg item structs.
interface spi_dfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       buffer_end;

   modport source (output valid, output rx_byte, output buffer_end, input ready);
   modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface spi_dfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [7:0]  frame_index;
   logic [15:0] payload_length;
   logic        last_of_frame;
   logic        buffer_done;
   logic        truncated;

   modport source (output valid, output kind, output data_byte, output frame_index,
                   output payload_length, output last_of_frame, output buffer_done,
                   output truncated, input ready);
   modport sink   (input valid, input kind, input data_byte, input frame_index,
                   input payload_length, input last_of_frame, input buffer_done,
                   input truncated, output ready);
endinterface

>>> sv/spi_dfr_in_reg.sv
// Input register of the deframer: holds one accepted byte transaction.
// Depends on spi_dfr_pkg.
module spi_dfr_in_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  spi_dfr_pkg::req_item_type req_item,
   input  logic                      advance,
   output logic                      item_valid,
   output spi_dfr_pkg::req_item_type item
);

   logic                      valid_ff;
   logic                      valid_in;
   spi_dfr_pkg::req_item_type item_ff;
   logic                      load;

   assign req_ready  = !valid_ff || advance;
   assign load       = req_valid && req_ready;
   assign valid_in   = load ? 1'b1 : (advance ? 1'b0 : valid_ff);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

endmodule

>>> sv/spi_dfr_core.sv
// Frame parser of the deframer: header check, payload tracking and buffer end.
// Depends on spi_dfr_pkg.
module spi_dfr_core #(
   parameter int unsigned BUFFER_BYTES = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  spi_dfr_pkg::req_item_type item,
   output logic                      produce,
   output spi_dfr_pkg::rsp_item_type result
);

   localparam logic [16:0] BUF_LIMIT = 17'(BUFFER_BYTES);

   spi_dfr_pkg::phase_type phase_ff, phase_in;
   logic [15:0]            pos_ff, pos_in;
   logic [15:0]            outer_ff, outer_in;
   logic [15:0]            inner_ff, inner_in;
   logic                   start_ok_ff, start_ok_in;
   logic [7:0]             frame_count_ff, frame_count_in;

   logic [15:0] pos_inc;
   logic        have;
   logic        boundary;
   logic        was_discard;
   logic        header_ok;

   assign pos_inc = pos_ff + 16'd1;

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      outer_in       = outer_ff;
      inner_in       = inner_ff;
      start_ok_in    = start_ok_ff;
      frame_count_in = frame_count_ff;
      have           = 1'b0;
      boundary       = 1'b0;
      header_ok      = 1'b0;
      was_discard    = 1'b0;
      result                = '0;
      result.kind           = spi_dfr_pkg::KIND_PAYLOAD;
      result.frame_index    = frame_count_ff;

      unique case (phase_ff) inside
         spi_dfr_pkg::PH_OUTER, spi_dfr_pkg::PH_START,
         spi_dfr_pkg::PH_INNER, spi_dfr_pkg::PH_RSVD: begin
            if (pos_ff == spi_dfr_pkg::POS_OUTER_HI) begin
               outer_in = {item.rx_byte, 8'h00};
            end else if (pos_ff == spi_dfr_pkg::POS_OUTER_LO) begin
               outer_in = {outer_ff[15:8], item.rx_byte};
            end else if (pos_ff >= spi_dfr_pkg::POS_START_LO &&
                         pos_ff <= spi_dfr_pkg::POS_START_HI) begin
               if (item.rx_byte != spi_dfr_pkg::START_BYTE) begin
                  start_ok_in = 1'b0;
               end
            end else if (pos_ff == spi_dfr_pkg::POS_INNER_LO) begin
               inner_in = {8'h00, item.rx_byte};
            end else if (pos_ff == spi_dfr_pkg::POS_INNER_HI) begin
               inner_in = {item.rx_byte, inner_ff[7:0]};
            end
            pos_in = pos_inc;
            if (pos_inc == spi_dfr_pkg::POS_CHECK) begin
               header_ok = start_ok_ff
                  && ({1'b0, inner_in} + spi_dfr_pkg::LEN_ADJUST == {1'b0, outer_ff})
                  && ({1'b0, outer_ff} + spi_dfr_pkg::FRAME_OVERHEAD <= BUF_LIMIT);
               if (!header_ok) begin
                  have        = 1'b1;
                  result.kind = spi_dfr_pkg::KIND_HDR_ERROR;
                  phase_in    = spi_dfr_pkg::PH_DISCARD;
                  pos_in      = '0;
               end else begin
                  phase_in = spi_dfr_pkg::PH_RSVD;
               end
            end else if (pos_inc >= spi_dfr_pkg::POS_HDR_END) begin
               phase_in = (inner_ff == '0) ? spi_dfr_pkg::PH_TRAILER
                                           : spi_dfr_pkg::PH_PAYLOAD;
               pos_in   = '0;
            end else if (pos_inc >= spi_dfr_pkg::POS_INNER_LO) begin
               phase_in = spi_dfr_pkg::PH_INNER;
            end else if (pos_inc >= spi_dfr_pkg::POS_START_LO) begin
               phase_in = spi_dfr_pkg::PH_START;
            end else begin
               phase_in = spi_dfr_pkg::PH_OUTER;
            end
         end
         spi_dfr_pkg::PH_PAYLOAD: begin
            have                  = 1'b1;
            result.data_byte      = item.rx_byte;
            result.payload_length = inner_ff;
            result.last_of_frame  = (pos_inc == inner_ff);
            pos_in                = pos_inc;
            if (pos_inc == inner_ff) begin
               phase_in = spi_dfr_pkg::PH_TRAILER;
               pos_in   = '0;
            end
         end
         spi_dfr_pkg::PH_TRAILER: begin
            pos_in = pos_inc;
            if (pos_inc >= spi_dfr_pkg::TRAILER_BYTES) begin
               boundary = 1'b1;
               if (frame_count_ff != spi_dfr_pkg::FRAME_MAX) begin
                  frame_count_in = frame_count_ff + 8'd1;
               end
               phase_in    = spi_dfr_pkg::PH_OUTER;
               pos_in      = '0;
               outer_in    = '0;
               inner_in    = '0;
               start_ok_in = 1'b1;
            end
         end
         default: begin
            // discard until the buffer closes
            was_discard = 1'b1;
         end
      endcase

      produce = have || item.buffer_end;

      if (item.buffer_end) begin
         if (!have) begin
            result                = '0;
            result.kind           = spi_dfr_pkg::KIND_BUFFER_END;
            result.frame_index    = frame_count_ff;
         end
         result.buffer_done = 1'b1;
         result.truncated   = !boundary && !was_discard;
         phase_in           = spi_dfr_pkg::PH_OUTER;
         pos_in             = '0;
         outer_in           = '0;
         inner_in           = '0;
         start_ok_in        = 1'b1;
         frame_count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= spi_dfr_pkg::PH_OUTER;
         pos_ff         <= '0;
         outer_ff       <= '0;
         inner_ff       <= '0;
         start_ok_ff    <= 1'b1;
         frame_count_ff <= '0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         outer_ff       <= outer_in;
         inner_ff       <= inner_in;
         start_ok_ff    <= start_ok_in;
         frame_count_ff <= frame_count_in;
      end
   end

   a_payload_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == spi_dfr_pkg::PH_PAYLOAD |-> inner_ff != '0)
      else $error("payload phase with zero inner length");

   a_payload_pos_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == spi_dfr_pkg::PH_PAYLOAD |-> pos_ff < inner_ff)
      else $error("payload position ran past inner length");

   a_header_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == spi_dfr_pkg::PH_OUTER || phase_ff == spi_dfr_pkg::PH_START ||
       phase_ff == spi_dfr_pkg::PH_INNER || phase_ff == spi_dfr_pkg::PH_RSVD)
      |-> pos_ff < spi_dfr_pkg::POS_HDR_END)
      else $error("header position out of range");

   a_buffer_end_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && item.buffer_end
      |=> phase_ff == spi_dfr_pkg::PH_OUTER && pos_ff == '0 && frame_count_ff == '0)
      else $error("state not cleared after buffer end");

endmodule

>>> sv/spi_dfr_out_reg.sv
// Result register of the deframer: holds one result transaction until taken.
// Depends on spi_dfr_pkg.
module spi_dfr_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  spi_dfr_pkg::rsp_item_type load_item,
   output logic                      slot_free,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output spi_dfr_pkg::rsp_item_type rsp_item
);

   logic                      valid_ff;
   logic                      valid_in;
   spi_dfr_pkg::rsp_item_type item_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign valid_in  = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

>>> sv/spi_rx_ethernet_deframer.sv
// Top level of the SPI receive-buffer Ethernet deframer.
// Depends on spi_dfr_pkg, spi_dfr_if, spi_dfr_in_reg, spi_dfr_core, spi_dfr_out_reg.
//
//   channel    dir  payload                                     transaction
//   req_chan   in   rx_byte, buffer_end                         one buffer byte
//   rsp_chan   out  kind, data_byte, frame_index,               zero or one per byte
//                   payload_length, last_of_frame,
//                   buffer_done, truncated
//
// One byte per cycle unless a byte's result waits on a stalled result register.
// The parser state between the input and result registers updates as each byte advances.
// A byte with no result advances even while the result register is stalled.
// Synchronous reset returns the parser to the outer length phase, frame count zero.
module spi_rx_ethernet_deframer #(
   parameter int unsigned BUFFER_BYTES = 4096
) (
   input  logic          clock,
   input  logic          reset,
   spi_dfr_req_if.sink   req_chan,
   spi_dfr_rsp_if.source rsp_chan
);

   spi_dfr_pkg::req_item_type req_item;
   spi_dfr_pkg::req_item_type item;
   spi_dfr_pkg::rsp_item_type result;
   spi_dfr_pkg::rsp_item_type rsp_item;
   logic item_valid;
   logic produce;
   logic slot_free;
   logic advance;

   assign req_item.rx_byte    = req_chan.rx_byte;
   assign req_item.buffer_end = req_chan.buffer_end;

   // hold the byte while its result has nowhere to go
   assign advance = item_valid && (!produce || slot_free);

   spi_dfr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   spi_dfr_core #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item),
      .produce (produce),
      .result  (result)
   );

   spi_dfr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && produce),
      .load_item (result),
      .slot_free (slot_free),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_chan.kind           = rsp_item.kind;
   assign rsp_chan.data_byte      = rsp_item.data_byte;
   assign rsp_chan.frame_index    = rsp_item.frame_index;
   assign rsp_chan.payload_length = rsp_item.payload_length;
   assign rsp_chan.last_of_frame  = rsp_item.last_of_frame;
   assign rsp_chan.buffer_done    = rsp_item.buffer_done;
   assign rsp_chan.truncated      = rsp_item.truncated;

endmodule

>>> verif/tb_spi_rx_ethernet_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench for spi_rx_ethernet_deframer: SPI buffer bytes in, results out.
// Depends on spi_dfr_pkg and the channel interfaces in spi_dfr_if; builds its own byte stream.
module tb_spi_rx_ethernet_deframer;

   localparam int unsigned BUF_BYTES       = 4096;
   localparam int unsigned HDR_OVERHEAD    = 10;     // inner length to outer length
   localparam int unsigned LEN_FIELD_BYTES = 4;      // outer length field itself
   localparam int unsigned MAX_INNER       = BUF_BYTES - LEN_FIELD_BYTES - HDR_OVERHEAD;
   localparam logic [7:0]  SYNC_BYTE       = 8'hAA;
   localparam int          N_DIRECTED      = 25;
   localparam int          RANDOM_ITEMS    = 1450;
   localparam int          LONG_FRAMES     = 40;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          DRAIN_CYCLES    = 10;
   localparam int          WATCHDOG_LIMIT  = 5000;
   localparam int          REPORT_LIMIT    = 10;

   typedef enum int {FLAW_NONE, FLAW_SYNC, FLAW_LENGTH, FLAW_OVERSIZE} flaw_type;

   // one buffer byte, with a hand-written result where the table gives one
   typedef struct packed {
      logic [7:0]                rx_byte;
      logic                      buffer_end;
      logic                      fixed;
      spi_dfr_pkg::rsp_item_type result;
   } stream_row_type;

   localparam spi_dfr_pkg::rsp_item_type NO_RESULT = '0;

   // empty-payload frame closing the buffer on its last trailer byte, then a header
   // whose lengths disagree with the buffer ending on its last inner length byte, then a lone end byte
   localparam stream_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h0A, 1'b0, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h55, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b1, '{spi_dfr_pkg::KIND_BUFFER_END, 8'h00, 8'h00, 16'h0000,
                             1'b0, 1'b1, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, 1'b1, '{spi_dfr_pkg::KIND_HDR_ERROR, 8'h00, 8'h00, 16'h0000,
                             1'b0, 1'b1, 1'b1}},
      '{8'h00, 1'b1, 1'b1, '{spi_dfr_pkg::KIND_BUFFER_END, 8'h00, 8'h00, 16'h0000,
                             1'b0, 1'b1, 1'b1}}
   };

   logic clock;
   logic reset;

   spi_dfr_req_if req_chan ();
   spi_dfr_rsp_if rsp_chan ();

   spi_rx_ethernet_deframer #(
      .BUFFER_BYTES (BUF_BYTES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   stream_row_type            rx_stream [$];
   spi_dfr_pkg::rsp_item_type due_results [$];

   // deframer state as the predictor sees it
   spi_dfr_pkg::phase_type dfr_phase;
   logic [15:0]            dfr_pos;
   logic [15:0]            dfr_outer;
   logic [15:0]            dfr_inner;
   logic                   dfr_start_ok;
   logic [7:0]             dfr_frames;

   int  mismatches;
   int  bytes_taken;
   int  results_seen;
   int  payload_seen;
   int  hdr_errors;
   int  truncations;
   int  buffers_closed;
   int  top_index;
   int  idle_cycles;
   bit  hold_armed;
   bit  hold_done;
   bit  quiet;

   function automatic void frame_restart();
      dfr_phase    = spi_dfr_pkg::PH_OUTER;
      dfr_pos      = '0;
      dfr_outer    = '0;
      dfr_inner    = '0;
      dfr_start_ok = 1'b1;
   endfunction

   // advance the parser by one byte; returns 1 when the byte yields a result
   function automatic bit deframe_byte(input logic [7:0] b, input logic closes,
                                       output spi_dfr_pkg::rsp_item_type r);
      bit          have;
      bit          boundary;
      bit          was_discard;
      bit          ok;
      logic [15:0] p;
      r           = '0;
      have        = 1'b0;
      boundary    = 1'b0;
      was_discard = (dfr_phase == spi_dfr_pkg::PH_DISCARD);
      r.frame_index = dfr_frames;
      if (dfr_phase <= spi_dfr_pkg::PH_RSVD) begin
         p = dfr_pos;
         if (p == 16'd2)
            dfr_outer = {b, 8'h00};
         else if (p == 16'd3)
            dfr_outer = dfr_outer | {8'h00, b};
         else if (p >= 16'd4 && p <= 16'd7) begin
            if (b != SYNC_BYTE)
               dfr_start_ok = 1'b0;
         end else if (p == 16'd8)
            dfr_inner = {8'h00, b};
         else if (p == 16'd9)
            dfr_inner = dfr_inner | {b, 8'h00};
         p = p + 16'd1;
         dfr_pos = p;
         if (p == 16'd10) begin
            ok = dfr_start_ok
                 && ({16'd0, dfr_inner} + HDR_OVERHEAD == {16'd0, dfr_outer})
                 && ({16'd0, dfr_outer} + LEN_FIELD_BYTES <= BUF_BYTES);
            if (!ok) begin
               have      = 1'b1;
               r.kind    = spi_dfr_pkg::KIND_HDR_ERROR;
               dfr_phase = spi_dfr_pkg::PH_DISCARD;
               dfr_pos   = '0;
            end else begin
               dfr_phase = spi_dfr_pkg::PH_RSVD;
            end
         end else if (p >= 16'd12) begin
            // empty payload skips straight to the trailer
            if (dfr_inner == 16'd0)
               dfr_phase = spi_dfr_pkg::PH_TRAILER;
            else
               dfr_phase = spi_dfr_pkg::PH_PAYLOAD;
            dfr_pos = '0;
         end else if (p >= 16'd8)
            dfr_phase = spi_dfr_pkg::PH_INNER;
         else if (p >= 16'd4)
            dfr_phase = spi_dfr_pkg::PH_START;
         else
            dfr_phase = spi_dfr_pkg::PH_OUTER;
      end else if (dfr_phase == spi_dfr_pkg::PH_PAYLOAD) begin
         have             = 1'b1;
         r.kind           = spi_dfr_pkg::KIND_PAYLOAD;
         r.data_byte      = b;
         r.payload_length = dfr_inner;
         r.last_of_frame  = ({16'd0, dfr_pos} + 32'd1 == {16'd0, dfr_inner});
         dfr_pos          = dfr_pos + 16'd1;
         if (r.last_of_frame) begin
            dfr_phase = spi_dfr_pkg::PH_TRAILER;
            dfr_pos   = '0;
         end
      end else if (dfr_phase == spi_dfr_pkg::PH_TRAILER) begin
         dfr_pos = dfr_pos + 16'd1;
         if (dfr_pos >= 16'd2) begin
            boundary = 1'b1;
            if (dfr_frames != 8'hFF)
               dfr_frames = dfr_frames + 8'd1;
            frame_restart();
         end
      end
      if (!have && !closes)
         return 1'b0;
      if (!have)
         r.kind = spi_dfr_pkg::KIND_BUFFER_END;
      r.buffer_done = closes;
      r.truncated   = closes && !boundary && !was_discard;
      if (closes) begin
         frame_restart();
         dfr_frames = '0;
      end
      return 1'b1;
   endfunction

   task automatic log_mismatch(input string what, input spi_dfr_pkg::rsp_item_type want,
                               input spi_dfr_pkg::rsp_item_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display({"%0t %s: expected kind=%0d byte=%02h frame=%0d len=%0d last=%b",
                   " done=%b trunc=%b,"},
                  $time, what, want.kind, want.data_byte, want.frame_index,
                  want.payload_length, want.last_of_frame, want.buffer_done, want.truncated,
                  "\n      got kind=%0d byte=%02h frame=%0d len=%0d last=%b done=%b trunc=%b",
                  got.kind, got.data_byte, got.frame_index, got.payload_length,
                  got.last_of_frame, got.buffer_done, got.truncated);
   endtask

   task automatic put_byte(input logic [7:0] b);
      rx_stream.push_back('{b, 1'b0, 1'b0, NO_RESULT});
   endtask

   // cut the buffer back to keep bytes (0 keeps all) and mark its last byte
   task automatic close_buffer(input int start, input int keep);
      if (keep > 0)
         while (rx_stream.size() > start + keep)
            void'(rx_stream.pop_back());
      rx_stream[rx_stream.size() - 1].buffer_end = 1'b1;
   endtask

   task automatic add_frame(input int unsigned payload_len, input flaw_type flaw);
      logic [15:0] inner;
      logic [15:0] outer;
      logic [7:0]  bad_byte;
      int unsigned bad_pos;
      inner    = payload_len[15:0];
      outer    = inner + 16'(HDR_OVERHEAD);
      bad_pos  = $urandom_range(4, 7);
      bad_byte = 8'($urandom_range(0, 254));
      if (bad_byte >= SYNC_BYTE)
         bad_byte = bad_byte + 8'd1;
      if (flaw == FLAW_LENGTH)
         outer = outer + 16'($urandom_range(1, 65535));
      else if (flaw == FLAW_OVERSIZE) begin
         inner = 16'($urandom_range(MAX_INNER + 1, 65535 - HDR_OVERHEAD));
         outer = inner + 16'(HDR_OVERHEAD);
      end
      // the upper two length bytes are ignored by the parser
      put_byte(8'($urandom));
      put_byte(8'($urandom));
      put_byte(outer[15:8]);
      put_byte(outer[7:0]);
      for (int k = 4; k < 8; k++)
         put_byte((flaw == FLAW_SYNC && k == bad_pos) ? bad_byte : SYNC_BYTE);
      put_byte(inner[7:0]);
      put_byte(inner[15:8]);
      if (flaw != FLAW_NONE) begin
         // junk that the block discards up to the buffer end
         repeat ($urandom_range(0, 12))
            put_byte(8'($urandom));
         return;
      end
      repeat (2 + payload_len + 2)
         put_byte(8'($urandom));
   endtask

   task automatic add_random_buffer();
      int          start;
      int          keep;
      int unsigned pick;
      int unsigned len_pick;
      int unsigned payload_len;
      start = rx_stream.size();
      keep  = 0;
      pick  = $urandom_range(0, 99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 24))
            put_byte(8'($urandom));
      end else if (pick < 15) begin
         // largest legal frame, cut early in its payload, or one byte too long, which fails the header check
         add_frame(MAX_INNER + $urandom_range(0, 1), FLAW_NONE);
         keep = 12 + $urandom_range(1, 30);
      end else begin
         repeat ($urandom_range(pick < 32 ? 0 : 1, 4)) begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 15)
               payload_len = 0;
            else if (len_pick < 80)
               payload_len = $urandom_range(1, 12);
            else if (len_pick < 96)
               payload_len = $urandom_range(13, 64);
            else
               payload_len = $urandom_range(65, 300);
            add_frame(payload_len, FLAW_NONE);
         end
         if (pick < 32)
            add_frame($urandom_range(0, 20),
                      flaw_type'($urandom_range(FLAW_SYNC, FLAW_OVERSIZE)));
         else if (pick < 48)
            keep = $urandom_range(1, rx_stream.size() - start);
      end
      close_buffer(start, keep);
   endtask

   // transaction monitor: predict on byte acceptance, compare on result acceptance
   always @(posedge clock) begin : scoreboard
      stream_row_type            row;
      spi_dfr_pkg::rsp_item_type predicted;
      spi_dfr_pkg::rsp_item_type seen;
      spi_dfr_pkg::rsp_item_type want;
      bit                        produced;
      if (reset) begin
         frame_restart();
         dfr_frames  = '0;
         idle_cycles = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            row = rx_stream[bytes_taken];
            bytes_taken++;
            produced = deframe_byte(row.rx_byte, row.buffer_end, predicted);
            if (row.fixed)
               due_results.push_back(row.result);
            else if (produced)
               due_results.push_back(predicted);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = '{spi_dfr_pkg::kind_type'(rsp_chan.kind), rsp_chan.data_byte,
                     rsp_chan.frame_index, rsp_chan.payload_length, rsp_chan.last_of_frame,
                     rsp_chan.buffer_done, rsp_chan.truncated};
            results_seen++;
            if (seen.kind == spi_dfr_pkg::KIND_PAYLOAD)
               payload_seen++;
            if (seen.kind == spi_dfr_pkg::KIND_HDR_ERROR)
               hdr_errors++;
            if (seen.buffer_done)
               buffers_closed++;
            if (seen.truncated)
               truncations++;
            if (int'(seen.frame_index) > top_index)
               top_index = int'(seen.frame_index);
            if (due_results.size() == 0) begin
               log_mismatch("result with nothing outstanding", NO_RESULT, seen);
            end else begin
               want = due_results.pop_front();
               if (seen.kind !== want.kind || seen.data_byte !== want.data_byte
                   || seen.frame_index !== want.frame_index
                   || seen.payload_length !== want.payload_length
                   || seen.last_of_frame !== want.last_of_frame
                   || seen.buffer_done !== want.buffer_done
                   || seen.truncated !== want.truncated)
                  log_mismatch("result mismatch", want, seen);
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, due_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off, none near the end
   initial begin : result_sink
      int unsigned run_len;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         rsp_chan.ready <= 1'b1;
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 25);
         repeat (run_len) @(posedge clock);
         if (hold_armed && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 1) == 1) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   initial begin : byte_source
      int long_start;
      int long_items;
      int hold_at;
      int quiet_at;
      bit sender_gaps;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.rx_byte    <= '0;
      req_chan.buffer_end <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         rx_stream.push_back(DIRECTED_ROWS[i]);
      while (rx_stream.size() < N_DIRECTED + RANDOM_ITEMS / 2)
         add_random_buffer();
      // one long buffer of back-to-back frames that walks the frame index up
      long_start = rx_stream.size();
      for (int f = 0; f < LONG_FRAMES; f++)
         add_frame(f < LONG_FRAMES - 8 ? 0 : $urandom_range(1, 3), FLAW_NONE);
      close_buffer(long_start, 0);
      long_items = rx_stream.size() - long_start;
      while (rx_stream.size() < N_DIRECTED + RANDOM_ITEMS)
         add_random_buffer();
      hold_at  = N_DIRECTED + 150;
      quiet_at = rx_stream.size() - 300;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_gaps = 1'b0;
      for (int i = 0; i < rx_stream.size(); i++) begin
         if (i == hold_at)
            hold_armed = 1'b1;
         if (i >= quiet_at)
            quiet = 1'b1;
         if (i % 150 == 0)
            sender_gaps = 1'($urandom_range(0, 1));
         if (!quiet && sender_gaps && $urandom_range(0, 7) == 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         req_chan.valid      <= 1'b1;
         req_chan.rx_byte    <= rx_stream[i].rx_byte;
         req_chan.buffer_end <= rx_stream[i].buffer_end;
         do @(posedge clock); while (!req_chan.ready);
      end
      req_chan.valid <= 1'b0;

      // let the monitor see the last transaction, then drain
      @(posedge clock);
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         mismatches += due_results.size();
         $display("%0d expected results never arrived", due_results.size());
      end

      $display("Fed %0d buffer bytes in %0d buffers, %0d of them in one %0d-frame buffer.",
               bytes_taken, buffers_closed, long_items, LONG_FRAMES);
      $display("Checked %0d results: %0d payload, %0d header errors, %0d truncated, top index %0d.",
               results_seen, payload_seen, hdr_errors, truncations, top_index);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
